// ===== hdl/prsf_pkg.sv =====
// Shared types, codes and widths of the pair repulsion and spring force block.
package prsf_pkg;

	localparam logic [1:0] CMD_SAME   = 2'd0;
	localparam logic [1:0] CMD_ADJ    = 2'd1;
	localparam logic [1:0] CMD_SPRING = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [1:0] REG_OPT    = 2'd0;
	localparam logic [1:0] REG_RGAIN  = 2'd1;
	localparam logic [1:0] REG_SGAIN  = 2'd2;

	localparam int POS_W  = 32;
	localparam int DIF_W  = 33;
	localparam int SQ_W   = 66;
	localparam int ROOT_W = 33;
	localparam int REM_W  = 35;
	localparam int Q_W    = 33;
	localparam int GP_W   = 65;
	localparam int OPT_W  = 31;
	localparam int GAIN_W = 32;
	localparam int MOB_W  = 17;
	localparam int SCL_W  = 18;
	localparam int MOB_FRAC = 16;

	localparam int QDEPTH = 4;
	localparam int QA_W   = 2;
	localparam int QC_W   = 3;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 136;

	localparam logic [OPT_W-1:0]  OPT_RST  = 31'd1310720;
	localparam logic [GAIN_W-1:0] GAIN_RST = 32'd6554;
	localparam logic [SCL_W-1:0]  MOB_ONE  = 18'd65536;
	localparam logic [SCL_W-1:0]  S_TWO    = 18'd131072;

	typedef struct packed {
		logic               live;
		logic               spring;
		logic               sxn;
		logic               sxp;
		logic               syn;
		logic               syp;
		logic [DIF_W-1:0]   adx;
		logic [DIF_W-1:0]   ady;
		logic [SCL_W-1:0]   s_a;
		logic [SCL_W-1:0]   s_b;
		logic [MOB_W-1:0]   mob_a;
		logic [MOB_W-1:0]   mob_b;
	} ent_t;

	typedef struct packed {
		logic               live;
		logic               spring;
		logic [3:0]         neg;
		logic [SCL_W-1:0]   s_a;
		logic [SCL_W-1:0]   s_b;
		logic [MOB_W-1:0]   mob_a;
		logic [MOB_W-1:0]   mob_b;
	} mid_t;

endpackage

// ===== hdl/prsf_front.sv =====
// Front end: takes a pair transfer, forms the offsets and classifies the pair.
module prsf_front (
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [prsf_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic [1:0]                            s_tuser,
	input  logic                                  full,
	output logic                                  push,
	output prsf_pkg::ent_t                        ent
);

	logic [prsf_pkg::POS_W-1:0] xa, ya, xb, yb;
	logic [prsf_pkg::MOB_W-1:0] mob_a, mob_b;
	logic act_a, act_b, fish_a, fish_b, pen;
	logic [prsf_pkg::DIF_W-1:0] dx, dy;
	logic [1:0] cmd;

	assign xa     = s_tdata[31:0];
	assign ya     = s_tdata[63:32];
	assign xb     = s_tdata[95:64];
	assign yb     = s_tdata[127:96];
	assign mob_a  = s_tdata[144:128];
	assign mob_b  = s_tdata[161:145];
	assign act_a  = s_tdata[162];
	assign act_b  = s_tdata[163];
	assign fish_a = s_tdata[164];
	assign fish_b = s_tdata[165];
	assign pen    = s_tdata[166];
	assign cmd    = s_tuser;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	assign dx = {xb[31], xb} - {xa[31], xa};
	assign dy = {yb[31], yb} - {ya[31], ya};

	always_comb begin
		ent.spring = (cmd == prsf_pkg::CMD_SPRING);
		ent.live   = act_a && act_b && pen && (cmd != prsf_pkg::CMD_NONE)
			&& !(ent.spring && (fish_a || fish_b)) && ((dx != '0) || (dy != '0));
		ent.sxn    = dx[32];
		ent.sxp    = !dx[32] && (dx != '0);
		ent.syn    = dy[32];
		ent.syp    = !dy[32] && (dy != '0);
		ent.adx    = dx[32] ? (~dx + 1'b1) : dx;
		ent.ady    = dy[32] ? (~dy + 1'b1) : dy;
		ent.mob_a  = mob_a;
		ent.mob_b  = mob_b;
		if (cmd == prsf_pkg::CMD_ADJ) begin
			ent.s_a = prsf_pkg::S_TWO - {1'b0, mob_a};
			ent.s_b = prsf_pkg::S_TWO - {1'b0, mob_b};
		end else begin
			ent.s_a = prsf_pkg::MOB_ONE;
			ent.s_b = prsf_pkg::MOB_ONE;
		end
	end

endmodule

// ===== hdl/prsf_queue.sv =====
// Short queue that decouples the front end from the force pipeline.
module prsf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prsf_pkg::ent_t din,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output prsf_pkg::ent_t dout
);

	logic [prsf_pkg::QA_W-1:0] wp_q, rp_q;
	logic [prsf_pkg::QC_W-1:0] cnt_q;
	prsf_pkg::ent_t            mem_q [prsf_pkg::QDEPTH];
	logic                      pop;

	assign full      = (cnt_q == prsf_pkg::QC_W'(prsf_pkg::QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= prsf_pkg::QC_W'(prsf_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("write into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a write");

endmodule

// ===== hdl/prsf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module prsf_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [prsf_pkg::SQ_W-1:0]     num,
	input  logic [prsf_pkg::Q_W-1:0]      den,
	output logic [prsf_pkg::Q_W-1:0]      quo
);

	localparam int N = prsf_pkg::Q_W;

	logic [N-1:0] rm_q [N], rm_in [N], rm_d [N];
	logic [N-1:0] rs_q [N], rs_in [N], rs_d [N];
	logic [N-1:0] qq_q [N], qq_in [N], qq_d [N];
	logic [N-1:0] dn_q [N], dn_in [N];
	logic [N:0]   cur [N];

	always_comb begin
		// top half stays below the divisor as the quotient fits in N bits
		rm_in[0] = num[2*N-1:N];
		rs_in[0] = num[N-1:0];
		qq_in[0] = '0;
		dn_in[0] = den;
		for (int j = 1; j < N; j++) begin
			rm_in[j] = rm_q[j-1];
			rs_in[j] = rs_q[j-1];
			qq_in[j] = qq_q[j-1];
			dn_in[j] = dn_q[j-1];
		end
		for (int j = 0; j < N; j++) begin
			cur[j]  = {rm_in[j], rs_in[j][N-1]};
			rs_d[j] = rs_in[j] << 1;
			if (cur[j] >= {1'b0, dn_in[j]}) begin
				rm_d[j] = N'(cur[j] - {1'b0, dn_in[j]});
				qq_d[j] = {qq_in[j][N-2:0], 1'b1};
			end else begin
				rm_d[j] = cur[j][N-1:0];
				qq_d[j] = {qq_in[j][N-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rm_q <= rm_d;
			rs_q <= rs_d;
			qq_q <= qq_d;
			dn_q <= dn_in;
		end
	end

	assign quo = qq_q[N-1];

endmodule

// ===== hdl/prsf_back.sv =====
// Force pipeline: square root, scaled quotient, gains and mobility scaling.
module prsf_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  prsf_pkg::ent_t                         ent,
	input  logic [prsf_pkg::OPT_W-1:0]             opt,
	input  logic [prsf_pkg::GAIN_W-1:0]            rgain,
	input  logic [prsf_pkg::GAIN_W-1:0]            sgain,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [prsf_pkg::OUT_DATA_W-1:0]        m_tdata
);

	localparam int SQ_N  = prsf_pkg::ROOT_W;
	localparam int DIV_N = prsf_pkg::Q_W;
	localparam int ENT_N = 2 + SQ_N;
	localparam int MQ    = 2 + DIV_N;
	localparam int MID_N = MQ + 7;
	localparam int LAT   = ENT_N + MID_N + 1;
	localparam int RW    = prsf_pkg::ROOT_W;
	localparam int SW    = prsf_pkg::SQ_W;
	localparam int EW    = prsf_pkg::REM_W;
	localparam int MW    = prsf_pkg::GP_W - FRAC_BITS;
	localparam int MH    = (MW + 1) / 2;
	localparam int TF    = MW + prsf_pkg::SCL_W;
	localparam int TW    = TF - prsf_pkg::MOB_FRAC;
	localparam int TH    = (TW + 1) / 2;
	localparam int UF    = TW + prsf_pkg::MOB_W;
	localparam int UW    = UF - prsf_pkg::MOB_FRAC;

	logic [LAT-1:0] vld_q;
	logic           en;

	prsf_pkg::ent_t ent_q [ENT_N];
	prsf_pkg::mid_t mid_q [MID_N];
	prsf_pkg::mid_t mid_d;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign in_ready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// squares and their sum
	logic [SW-1:0] sqx_s1, sqy_s1, sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= ent.adx * ent.adx;
			sqy_s1 <= ent.ady * ent.ady;
			sum_s2 <= sqx_s1 + sqy_s1;
			ent_q[0] <= ent;
			for (int i = 1; i < ENT_N; i++) ent_q[i] <= ent_q[i-1];
		end
	end

	// integer square root, two radicand bits per stage
	logic [RW-1:0]  rt_q [SQ_N], rt_in [SQ_N], rt_d [SQ_N];
	logic [EW-1:0]  rm_q [SQ_N], rm_in [SQ_N], rm_d [SQ_N];
	logic [SW-1:0]  rd_q [SQ_N], rd_in [SQ_N], rd_d [SQ_N];
	logic [EW+1:0]  sq_cur [SQ_N], sq_try [SQ_N];

	always_comb begin
		rt_in[0] = '0;
		rm_in[0] = '0;
		rd_in[0] = sum_s2;
		for (int j = 1; j < SQ_N; j++) begin
			rt_in[j] = rt_q[j-1];
			rm_in[j] = rm_q[j-1];
			rd_in[j] = rd_q[j-1];
		end
		for (int j = 0; j < SQ_N; j++) begin
			sq_cur[j] = {rm_in[j], rd_in[j][SW-1 -: 2]};
			sq_try[j] = {2'b00, rt_in[j], 2'b01};
			rd_d[j]   = rd_in[j] << 2;
			if (sq_cur[j] >= sq_try[j]) begin
				rt_d[j] = {rt_in[j][RW-2:0], 1'b1};
				rm_d[j] = EW'(sq_cur[j] - sq_try[j]);
			end else begin
				rt_d[j] = {rt_in[j][RW-2:0], 1'b0};
				rm_d[j] = sq_cur[j][EW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_q <= rt_d;
			rm_q <= rm_d;
			rd_q <= rd_d;
		end
	end

	// distance error, gating and push direction
	prsf_pkg::ent_t ed;
	logic [RW-1:0]  root_v, opt_w, diff_c;
	logic           gt, pull;

	assign ed    = ent_q[ENT_N-1];
	assign root_v = rt_q[SQ_N-1];
	assign opt_w = RW'(opt);
	assign gt    = root_v > opt_w;
	assign diff_c = gt ? (root_v - opt_w) : (opt_w - root_v);
	assign pull  = ed.spring && gt;

	always_comb begin
		mid_d.live   = ed.live && (ed.spring || (!gt && (root_v != opt_w)));
		mid_d.spring = ed.spring;
		mid_d.neg[0] = pull ? ed.sxn : ed.sxp;
		mid_d.neg[1] = pull ? ed.syn : ed.syp;
		mid_d.neg[2] = pull ? ed.sxp : ed.sxn;
		mid_d.neg[3] = pull ? ed.syp : ed.syn;
		mid_d.s_a    = ed.s_a;
		mid_d.s_b    = ed.s_b;
		mid_d.mob_a  = ed.mob_a;
		mid_d.mob_b  = ed.mob_b;
	end

	logic [RW-1:0] diff_sD, d_sD, d_sP, d_sQ;
	logic [prsf_pkg::DIF_W-1:0] adx_sD, ady_sD;
	logic [prsf_pkg::DIF_W+16:0] plx_sP, ply_sP;
	logic [prsf_pkg::DIF_W+15:0] phx_sP, phy_sP;
	logic [SW-1:0] prx_sQ, pry_sQ;

	always_ff @(posedge clk) begin
		if (en) begin
			mid_q[0] <= mid_d;
			for (int i = 1; i < MID_N; i++) mid_q[i] <= mid_q[i-1];
			diff_sD <= diff_c;
			d_sD    <= root_v;
			adx_sD  <= ed.adx;
			ady_sD  <= ed.ady;
			plx_sP  <= adx_sD * diff_sD[16:0];
			phx_sP  <= adx_sD * diff_sD[RW-1:17];
			ply_sP  <= ady_sD * diff_sD[16:0];
			phy_sP  <= ady_sD * diff_sD[RW-1:17];
			d_sP    <= d_sD;
			prx_sQ  <= SW'(plx_sP) + (SW'(phx_sP) << 17);
			pry_sQ  <= SW'(ply_sP) + (SW'(phy_sP) << 17);
			d_sQ    <= d_sP;
		end
	end

	logic [prsf_pkg::Q_W-1:0] qx, qy;

	prsf_div u_div_x (.clk(clk), .en(en), .num(prx_sQ), .den(d_sQ), .quo(qx));
	prsf_div u_div_y (.clk(clk), .en(en), .num(pry_sQ), .den(d_sQ), .quo(qy));

	// gain product, then scale by the other node's share and own mobility
	logic [prsf_pkg::GAIN_W-1:0] gain;
	logic [prsf_pkg::Q_W+15:0]   glx_sG, ghx_sG, gly_sG, ghy_sG;
	logic [MW-1:0]               mx_sH, my_sH;

	assign gain = mid_q[MQ].spring ? sgain : rgain;

	always_ff @(posedge clk) begin
		if (en) begin
			glx_sG <= qx * gain[15:0];
			ghx_sG <= qx * gain[31:16];
			gly_sG <= qy * gain[15:0];
			ghy_sG <= qy * gain[31:16];
			mx_sH  <= MW'((prsf_pkg::GP_W'(glx_sG) + (prsf_pkg::GP_W'(ghx_sG) << 16))
				>> FRAC_BITS);
			my_sH  <= MW'((prsf_pkg::GP_W'(gly_sG) + (prsf_pkg::GP_W'(ghy_sG) << 16))
				>> FRAC_BITS);
		end
	end

	logic [MW-1:0]                  m_k  [4];
	logic [prsf_pkg::SCL_W-1:0]     s_k  [4];
	logic [prsf_pkg::MOB_W-1:0]     mb_k [4];
	logic [MH+prsf_pkg::SCL_W-1:0]  sl_sS [4];
	logic [MW-MH+prsf_pkg::SCL_W-1:0] sh_sS [4];
	logic [TW-1:0]                  t_sT [4];
	logic [TH+prsf_pkg::MOB_W-1:0]  ul_sM [4];
	logic [TW-TH+prsf_pkg::MOB_W-1:0] uh_sM [4];
	logic [UW-1:0]                  u_sU [4];
	logic [31:0]                    res_c [4];
	logic [31:0]                    res_q [4];
	logic                           frc_q;
	prsf_pkg::mid_t                 mo;

	assign mo = mid_q[MQ+6];

	// lanes: a x, a y, b x, b y
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			m_k[k]  = k[0] ? my_sH : mx_sH;
			s_k[k]  = (k < 2) ? mid_q[MQ+2].s_b : mid_q[MQ+2].s_a;
			mb_k[k] = (k < 2) ? mid_q[MQ+4].mob_a : mid_q[MQ+4].mob_b;
			if (!mo.live) begin
				res_c[k] = '0;
			end else if (mo.neg[k]) begin
				if ((|u_sU[k][UW-1:32]) || (u_sU[k][31] && (|u_sU[k][30:0])))
					res_c[k] = 32'h8000_0000;
				else
					res_c[k] = ~u_sU[k][31:0] + 1'b1;
			end else begin
				if ((|u_sU[k][UW-1:32]) || u_sU[k][31])
					res_c[k] = 32'h7FFF_FFFF;
				else
					res_c[k] = u_sU[k][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				sl_sS[k] <= m_k[k][MH-1:0] * s_k[k];
				sh_sS[k] <= m_k[k][MW-1:MH] * s_k[k];
				t_sT[k]  <= TW'((TF'(sl_sS[k]) + (TF'(sh_sS[k]) << MH))
					>> prsf_pkg::MOB_FRAC);
				ul_sM[k] <= t_sT[k][TH-1:0] * mb_k[k];
				uh_sM[k] <= t_sT[k][TW-1:TH] * mb_k[k];
				u_sU[k]  <= UW'((UF'(ul_sM[k]) + (UF'(uh_sM[k]) << TH))
					>> prsf_pkg::MOB_FRAC);
				res_q[k] <= res_c[k];
			end
			frc_q <= (res_c[0] != '0) || (res_c[1] != '0) || (res_c[2] != '0)
				|| (res_c[3] != '0);
		end
	end

	assign m_tdata = {7'b0, frc_q, res_q[3], res_q[2], res_q[1], res_q[0]};

endmodule

// ===== hdl/pair_repulsion_spring_force.sv =====
// Top level of the pair repulsion and chain spring force block.
// One node pair is taken per clock and one result leaves per clock in steady
// state while results are taken; the pipeline depth after the input queue
// comes chiefly from the 33-stage square root and 33-stage divider of the
// force pipeline. A four-entry queue sits between the input side and the
// pipeline, and the whole pipeline holds while a finished result is not
// taken. Configuration is written through its own port, index 0 the optimal
// distance, 1 the repulsion gain, 2 the spring gain; other indexes are
// ignored. No start-up pass is needed after reset.
module pair_repulsion_spring_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// pos_x_a, pos_y_a, pos_x_b, pos_y_b, mobility_a, mobility_b,
	// active_a, active_b, fish_a, fish_b, pair_enable, one pad bit
	input  logic [167:0]  s_tdata,
	// cmd
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// dvx_a, dvy_a, dvx_b, dvy_b, force_applied, seven pad bits
	output logic [135:0]  m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	logic [prsf_pkg::OPT_W-1:0]  opt_q;
	logic [prsf_pkg::GAIN_W-1:0] rgain_q, sgain_q;
	logic                        push, full, q_valid, q_ready;
	prsf_pkg::ent_t              ent_in, ent_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_q   <= prsf_pkg::OPT_RST;
			rgain_q <= prsf_pkg::GAIN_RST;
			sgain_q <= prsf_pkg::GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				prsf_pkg::REG_OPT:   opt_q   <= cfg_data[30:0];
				prsf_pkg::REG_RGAIN: rgain_q <= cfg_data;
				prsf_pkg::REG_SGAIN: sgain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	prsf_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.ent      (ent_in)
	);

	prsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (ent_in),
		.full      (full),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.dout      (ent_head)
	);

	prsf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.ent      (ent_head),
		.opt      (opt_q),
		.rgain    (rgain_q),
		.sgain    (sgain_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_force_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[128] == (m_tdata[127:0] != '0)))
		else $error("force flag disagrees with increments");

endmodule
